>>> design/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true outside reset.
`define MSW_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg
// Shared types and constants of the multi-scale window scanner.
// ----------------------------------------------------------------------------
package msw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int FRAME_W    = 13;
    localparam int BOX_W      = 13;
    localparam int SCALE_W    = 5;
    localparam int MINWIN_W   = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW   = 3'd5;

    localparam logic [3:0] DIV_BY_5  = 4'd5;
    localparam logic [3:0] DIV_BY_6  = 4'd6;
    localparam logic [3:0] DIV_BY_10 = 4'd10;

    typedef struct packed {
        logic ld_start;
        logic adv;
        logic shr_go;
        logic shr_ld;
        logic grow_go;
        logic grow_ld;
        logic step_go;
        logic step_ld;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic shr_cont;
        logic wrap_y;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> design/msw_cdiv.sv
// ----------------------------------------------------------------------------
// msw_cdiv
// Divider by a small constant through a reciprocal multiply; operands and quotient are registered.
// ----------------------------------------------------------------------------
module msw_cdiv #(
    parameter int DW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [3:0]    divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    // Reciprocals are rounded up with DW+4 fraction bits; the rounding error
    // stays below the divisor, so floor(x * rcp >> SH) is exact for any DW-bit x.
    localparam int SH = DW + 4;
    localparam int MW = DW + 2;
    localparam int PW = DW + MW;

    localparam logic [MW-1:0] RCP_5  = MW'(((64'd1 << SH) + 64'd4) / 64'd5);
    localparam logic [MW-1:0] RCP_6  = MW'(((64'd1 << SH) + 64'd5) / 64'd6);
    localparam logic [MW-1:0] RCP_10 = MW'(((64'd1 << SH) + 64'd9) / 64'd10);

    logic [DW-1:0] dvd_reg;
    logic [MW-1:0] rcp_reg, rcp;
    logic [PW-1:0] prod;
    logic [DW-1:0] q_reg;
    logic          mul_reg, done_reg;

    always_comb begin
        unique case (divisor)
            msw_pkg::DIV_BY_5:  rcp = RCP_5;
            msw_pkg::DIV_BY_6:  rcp = RCP_6;
            msw_pkg::DIV_BY_10: rcp = RCP_10;
            default:            rcp = '0;
        endcase
        prod = PW'(dvd_reg) * PW'(rcp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= start;
            done_reg <= mul_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rcp_reg <= rcp;
        end
        if (mul_reg) begin
            q_reg <= DW'(prod[PW-1:SH]);
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> design/msw_dp.sv
// ----------------------------------------------------------------------------
// msw_dp
// Window scanner datapath: config registers, scan state, dividers, output word.
// ----------------------------------------------------------------------------
module msw_dp #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8,
    parameter int COUNT_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  msw_pkg::dp_cmd_t                   cmd,
    output msw_pkg::dp_stat_t                  stat,
    input  logic                               cfg_we,
    input  logic [msw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic                               o_box_valid,
    output logic [COUNT_BITS-1:0]              o_box_id,
    output logic [COORD_BITS-1:0]              o_left_x,
    output logic [COORD_BITS-1:0]              o_top_y,
    output logic [COORD_BITS:0]                o_right_x,
    output logic [COORD_BITS:0]                o_bottom_y,
    output logic                               o_more
);
    localparam int WIN_W  = COORD_BITS + 1 + FRAC_BITS;
    localparam int RND_W  = COORD_BITS + 2;
    localparam int DIV_W  = WIN_W + 3;
    localparam int FRM_W  = msw_pkg::FRAME_W + FRAC_BITS;
    localparam int MWF_W  = msw_pkg::MINWIN_W + FRAC_BITS;
    localparam int CMP_W  = ((WIN_W > MWF_W) ? WIN_W : MWF_W) + 3;
    localparam int HM_W   = ((WIN_W > FRM_W) ? WIN_W : FRM_W) + 1;
    localparam int LIM_W  = ((FRM_W > RND_W + FRAC_BITS) ? FRM_W : RND_W + FRAC_BITS) + 2;
    localparam int BOXF_W = msw_pkg::BOX_W + FRAC_BITS + WIN_W;

    localparam logic [WIN_W-1:0] ONE_FX  = WIN_W'(1) << FRAC_BITS;
    localparam logic [WIN_W-1:0] TWO_FX  = WIN_W'(2) << FRAC_BITS;
    localparam logic [WIN_W:0]   HALF_FX = (WIN_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [WIN_W-1:0] WIN_MAX = '1;

    // configuration
    logic [msw_pkg::FRAME_W-1:0]  frame_w_reg, frame_h_reg;
    logic [msw_pkg::BOX_W-1:0]    box_w_reg, box_h_reg;
    logic [msw_pkg::SCALE_W-1:0]  max_scale_reg;
    logic [msw_pkg::MINWIN_W-1:0] min_win_reg;

    // scan state
    logic [WIN_W-1:0]             win_w_reg, win_h_reg, pos_x_reg, pos_y_reg;
    logic [WIN_W-1:0]             step_x_reg, step_y_reg;
    logic signed [LIM_W-1:0]      lim_x_reg, lim_y_reg;
    logic [msw_pkg::SCALE_W-1:0]  scales_reg, shr_n_reg;
    logic [COUNT_BITS-1:0]        count_reg;

    // held result fields
    logic                         h_valid_reg;
    logic [COUNT_BITS-1:0]        h_id_reg;
    logic [COORD_BITS-1:0]        h_left_reg, h_top_reg;
    logic [COORD_BITS:0]          h_right_reg, h_bottom_reg;

    logic                         out_valid_reg;

    logic [FRM_W-1:0]             frame_w_fx, frame_h_fx;
    logic [MWF_W-1:0]             min_fx;
    logic [CMP_W-1:0]             w5, h5, lim6;
    logic [WIN_W:0]               rsum_w, rsum_h, rsum_px, rsum_py, rsum_r, rsum_b;
    logic [RND_W-1:0]             rw, rh;
    logic [WIN_W:0]               nx, ny;
    logic                         wrap_x, wrap_y, has_more;
    logic [COORD_BITS-1:0]        f_left, f_top;
    logic [COORD_BITS:0]          f_right, f_bottom;
    logic [BOXF_W-1:0]            box_w_fx, box_h_fx;

    logic                         div_go, done_w, done_h;
    logic [DIV_W-1:0]             dvd_w, dvd_h, q_w, q_h;
    logic [3:0]                   dvsr;
    logic [WIN_W-1:0]             grow_w, grow_h;

    always_comb begin
        frame_w_fx = {frame_w_reg, {FRAC_BITS{1'b0}}};
        frame_h_fx = {frame_h_reg, {FRAC_BITS{1'b0}}};
        min_fx     = {min_win_reg, {FRAC_BITS{1'b0}}};
        w5   = CMP_W'({win_w_reg, 2'b00}) + CMP_W'(win_w_reg);
        h5   = CMP_W'({win_h_reg, 2'b00}) + CMP_W'(win_h_reg);
        lim6 = CMP_W'({min_fx, 2'b00}) + CMP_W'({min_fx, 1'b0});

        rsum_w = (WIN_W + 1)'(win_w_reg) + HALF_FX;
        rsum_h = (WIN_W + 1)'(win_h_reg) + HALF_FX;
        rw     = rsum_w[WIN_W:FRAC_BITS];
        rh     = rsum_h[WIN_W:FRAC_BITS];

        rsum_px = (WIN_W + 1)'(pos_x_reg) + HALF_FX;
        rsum_py = (WIN_W + 1)'(pos_y_reg) + HALF_FX;
        rsum_r  = (WIN_W + 1)'(pos_x_reg) + (WIN_W + 1)'(win_w_reg)
                  - (WIN_W + 1)'(ONE_FX) + HALF_FX;
        rsum_b  = (WIN_W + 1)'(pos_y_reg) + (WIN_W + 1)'(win_h_reg)
                  - (WIN_W + 1)'(ONE_FX) + HALF_FX;
        f_left   = rsum_px[FRAC_BITS +: COORD_BITS];
        f_top    = rsum_py[FRAC_BITS +: COORD_BITS];
        f_right  = rsum_r[FRAC_BITS +: COORD_BITS + 1];
        f_bottom = rsum_b[FRAC_BITS +: COORD_BITS + 1];

        nx     = (WIN_W + 1)'(pos_x_reg) + (WIN_W + 1)'(step_x_reg);
        ny     = (WIN_W + 1)'(pos_y_reg) + (WIN_W + 1)'(step_y_reg);
        wrap_x = $signed(LIM_W'(nx)) > lim_x_reg;
        wrap_y = wrap_x && ($signed(LIM_W'(ny)) > lim_y_reg);

        has_more = (HM_W'(win_w_reg) < HM_W'(frame_w_fx)) &&
                   (HM_W'(win_h_reg) < HM_W'(frame_h_fx)) && (scales_reg != '0);

        box_w_fx = BOXF_W'(box_w_reg) << FRAC_BITS;
        box_h_fx = BOXF_W'(box_h_reg) << FRAC_BITS;

        grow_w = (q_w > DIV_W'(WIN_MAX)) ? WIN_MAX : q_w[WIN_W-1:0];
        grow_h = (q_h > DIV_W'(WIN_MAX)) ? WIN_MAX : q_h[WIN_W-1:0];
    end

    // divider operand select
    always_comb begin
        div_go = cmd.shr_go || cmd.grow_go || cmd.step_go;
        if (cmd.shr_go) begin
            dvd_w = DIV_W'(w5);
            dvd_h = DIV_W'(h5);
            dvsr  = msw_pkg::DIV_BY_6;
        end else if (cmd.grow_go) begin
            dvd_w = DIV_W'({win_w_reg, 2'b00}) + DIV_W'({win_w_reg, 1'b0});
            dvd_h = DIV_W'({win_h_reg, 2'b00}) + DIV_W'({win_h_reg, 1'b0});
            dvsr  = msw_pkg::DIV_BY_5;
        end else begin
            dvd_w = DIV_W'({rw, {FRAC_BITS{1'b0}}});
            dvd_h = DIV_W'({rh, {FRAC_BITS{1'b0}}});
            dvsr  = msw_pkg::DIV_BY_10;
        end
    end

    msw_cdiv #(.DW(DIV_W)) u_div_w (
        .aclk(aclk), .aresetn(aresetn), .start(div_go), .dividend(dvd_w),
        .divisor(dvsr), .done(done_w), .quotient(q_w)
    );

    msw_cdiv #(.DW(DIV_W)) u_div_h (
        .aclk(aclk), .aresetn(aresetn), .start(div_go), .dividend(dvd_h),
        .divisor(dvsr), .done(done_h), .quotient(q_h)
    );

    always_comb begin
        stat.shr_cont = (w5 > lim6) && (h5 > lim6) && (shr_n_reg < max_scale_reg);
        stat.wrap_y   = wrap_y;
        stat.div_done = done_w && done_h;
        stat.out_free = !out_valid_reg || m_tready;
    end

    // config and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg   <= msw_pkg::FRAME_W'(320);
            frame_h_reg   <= msw_pkg::FRAME_W'(240);
            box_w_reg     <= msw_pkg::BOX_W'(32);
            box_h_reg     <= msw_pkg::BOX_W'(32);
            max_scale_reg <= msw_pkg::SCALE_W'(10);
            min_win_reg   <= msw_pkg::MINWIN_W'(24);
            win_w_reg     <= '0;
            win_h_reg     <= '0;
            pos_x_reg     <= TWO_FX;
            pos_y_reg     <= TWO_FX;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            lim_x_reg     <= '0;
            lim_y_reg     <= '0;
            scales_reg    <= '0;
            shr_n_reg     <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    msw_pkg::REG_FRAME_WIDTH:  frame_w_reg   <= cfg_data;
                    msw_pkg::REG_FRAME_HEIGHT: frame_h_reg   <= cfg_data;
                    msw_pkg::REG_BOX_WIDTH:    box_w_reg     <= cfg_data;
                    msw_pkg::REG_BOX_HEIGHT:   box_h_reg     <= cfg_data;
                    msw_pkg::REG_MAX_SCALE:    max_scale_reg <= cfg_data[msw_pkg::SCALE_W-1:0];
                    msw_pkg::REG_MIN_WINDOW:   min_win_reg   <= cfg_data[msw_pkg::MINWIN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.ld_start) begin
                win_w_reg  <= box_w_fx[WIN_W-1:0];
                win_h_reg  <= box_h_fx[WIN_W-1:0];
                pos_x_reg  <= TWO_FX;
                pos_y_reg  <= TWO_FX;
                scales_reg <= max_scale_reg;
                shr_n_reg  <= '0;
                count_reg  <= '0;
            end
            if (cmd.adv) begin
                count_reg <= count_reg + 1'b1;
                if (wrap_x) begin
                    pos_x_reg <= TWO_FX;
                    pos_y_reg <= wrap_y ? TWO_FX : ny[WIN_W-1:0];
                end else begin
                    pos_x_reg <= nx[WIN_W-1:0];
                end
            end
            if (cmd.shr_ld) begin
                win_w_reg <= q_w[WIN_W-1:0];
                win_h_reg <= q_h[WIN_W-1:0];
                shr_n_reg <= shr_n_reg + 1'b1;
            end
            if (cmd.grow_ld) begin
                win_w_reg <= grow_w;
                win_h_reg <= grow_h;
                if (scales_reg != '0) begin
                    scales_reg <= scales_reg - 1'b1;
                end
            end
            if (cmd.step_ld) begin
                step_x_reg <= (q_w < q_h) ? q_w[WIN_W-1:0] : q_h[WIN_W-1:0];
                step_y_reg <= q_h[WIN_W-1:0];
                lim_x_reg  <= $signed(LIM_W'(frame_w_fx)) - $signed(LIM_W'({rw, {FRAC_BITS{1'b0}}}))
                              - $signed(LIM_W'(ONE_FX));
                lim_y_reg  <= $signed(LIM_W'(frame_h_fx)) - $signed(LIM_W'({rh, {FRAC_BITS{1'b0}}}))
                              - $signed(LIM_W'(ONE_FX));
            end
        end
    end

    // held fields for results that finish later
    always_ff @(posedge aclk) begin
        if (cmd.ld_start) begin
            h_valid_reg  <= 1'b0;
            h_id_reg     <= '0;
            h_left_reg   <= '0;
            h_top_reg    <= '0;
            h_right_reg  <= '0;
            h_bottom_reg <= '0;
        end else if (cmd.adv) begin
            h_valid_reg  <= 1'b1;
            h_id_reg     <= count_reg;
            h_left_reg   <= f_left;
            h_top_reg    <= f_top;
            h_right_reg  <= f_right;
            h_bottom_reg <= f_bottom;
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || (cmd.adv && !wrap_y)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            o_box_valid <= h_valid_reg;
            o_box_id    <= h_id_reg;
            o_left_x    <= h_left_reg;
            o_top_y     <= h_top_reg;
            o_right_x   <= h_right_reg;
            o_bottom_y  <= h_bottom_reg;
            o_more      <= has_more;
        end else if (cmd.adv && !wrap_y) begin
            o_box_valid <= 1'b1;
            o_box_id    <= count_reg;
            o_left_x    <= f_left;
            o_top_y     <= f_top;
            o_right_x   <= f_right;
            o_bottom_y  <= f_bottom;
            o_more      <= has_more;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> design/msw_ctrl.sv
// ----------------------------------------------------------------------------
// msw_ctrl
// Window scanner sequencer: restart shrink loop, scale growth, step setup.
// ----------------------------------------------------------------------------
module msw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              restart,
    output logic              s_tready,
    input  msw_pkg::dp_stat_t stat,
    output msw_pkg::dp_cmd_t  cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHR_TEST,
        ST_SHR_WAIT,
        ST_GROW_WAIT,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (restart) begin
                        cmd.ld_start = 1'b1;
                        state_next   = ST_SHR_TEST;
                    end else begin
                        cmd.adv = 1'b1;
                        if (stat.wrap_y) begin
                            cmd.grow_go = 1'b1;
                            state_next  = ST_GROW_WAIT;
                        end
                    end
                end
            end
            ST_SHR_TEST: begin
                if (stat.shr_cont) begin
                    cmd.shr_go = 1'b1;
                    state_next = ST_SHR_WAIT;
                end else begin
                    cmd.step_go = 1'b1;
                    state_next  = ST_STEP_WAIT;
                end
            end
            ST_SHR_WAIT: begin
                if (stat.div_done) begin
                    cmd.shr_ld = 1'b1;
                    state_next = ST_SHR_TEST;
                end
            end
            ST_GROW_WAIT: begin
                if (stat.div_done) begin
                    cmd.grow_ld = 1'b1;
                    state_next  = ST_STEP_GO;
                end
            end
            ST_STEP_GO: begin
                cmd.step_go = 1'b1;
                state_next  = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (stat.div_done) begin
                    cmd.step_ld = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/multi_scale_window_scanner.sv
// ----------------------------------------------------------------------------
// multi_scale_window_scanner
// Raster scan of detection windows over a frame at several scales.
// ----------------------------------------------------------------------------
// Input word (s_tdata[0] = restart): 1 restarts the scan from the config
// registers and returns an acknowledge word (m_tuser = 0); 0 returns the next
// window (m_tuser = 1) with its id, rounded corners and a more-windows flag.
// Config writes (cfg_valid/cfg_index/cfg_data) are always taken; write them
// only while no word is in flight.
// Sequencing: an advance inside a raster gives its word in the cycle after it
// is taken, and the next word can be taken in the next cycle if the receiver
// takes that word. An advance that ends a raster runs a grow division and then
// a step division before its word is emitted, and no input is taken meanwhile.
// A restart runs its shrink divisions and a step division before its
// acknowledge word, shrinks <= max_scale. The reciprocal dividers set the waits.
// The output register holds one word; a new word is taken while it waits
// only if the receiver takes it in the same cycle. While m_tready is low the
// word holds and no input is taken.
// Reset (aresetn low, synchronous) restores the config defaults, clears the
// scan state and drops m_tvalid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_scale_window_scanner #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8,
    parameter int COUNT_BITS = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // s_tdata: [0] restart
    input  logic [7:0]                                s_tdata,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [msw_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [msw_pkg::CFG_DATA_W-1:0]            cfg_data,
    // m_tdata: box_id, left_x, top_y, right_x, bottom_y, more_windows, zero pad
    output logic [((COUNT_BITS+4*COORD_BITS+3+7)/8)*8-1:0] m_tdata,
    // m_tuser: [0] box_valid
    output logic                                      m_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready
);
    localparam int PAY_W = COUNT_BITS + 4 * COORD_BITS + 3;
    localparam int OUT_W = ((PAY_W + 7) / 8) * 8;

    msw_pkg::dp_cmd_t  cmd;
    msw_pkg::dp_stat_t stat;

    logic [COUNT_BITS-1:0] box_id;
    logic [COORD_BITS-1:0] left_x, top_y;
    logic [COORD_BITS:0]   right_x, bottom_y;
    logic                  more;

    assign cfg_ready = 1'b1;

    msw_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .restart(s_tdata[0]),
        .s_tready(s_tready), .stat(stat), .cmd(cmd)
    );

    msw_dp #(
        .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .o_box_valid(m_tuser),
        .o_box_id(box_id), .o_left_x(left_x), .o_top_y(top_y),
        .o_right_x(right_x), .o_bottom_y(bottom_y), .o_more(more)
    );

    assign m_tdata = OUT_W'({more, bottom_y, right_x, top_y, left_x, box_id});

    // an input word never enters while a result is stalled
    `MSW_ASSERT_NEVER(a_no_take_on_stall, aclk, aresetn,
        s_tvalid && s_tready && m_tvalid && !m_tready)
    // a restart always runs the shrink sequencer before the next word
    `MSW_ASSERT_NEXT(a_restart_busy, aclk, aresetn,
        s_tvalid && s_tready && s_tdata[0], !s_tready)

endmodule

>>> tb/sv/multi_scale_window_scanner_tb.sv
// ----------------------------------------------------------------------------
// multi_scale_window_scanner_tb
// Self-checking bench for the multi-scale window scanner. A directed table
// and random restart/advance words run under several register settings,
// including the extremes. Each result word is checked against a local model
// of the raster walk, the shrink search and the grow steps. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module multi_scale_window_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = 8;
    localparam longint unsigned ONE_FX  = 64'd256;
    localparam longint unsigned HALF_FX = 64'd128;
    localparam longint unsigned WIN_MAX = (64'd1 << 21) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic        box_valid;
        logic [23:0] box_id;
        logic [11:0] left_x;
        logic [11:0] top_y;
        logic [12:0] right_x;
        logic [12:0] bottom_y;
        logic        more_windows;
    } window_t;

    typedef struct {
        logic    restart;
        logic    typed;
        window_t result;
    } stim_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic [7:0]                     s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [msw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [msw_pkg::CFG_DATA_W-1:0] cfg_data;
    logic [79:0]                    m_tdata;
    logic                           m_tuser;
    logic                           m_tvalid;
    logic                           m_tready;

    multi_scale_window_scanner dut (.*);

    // scanner shadow
    longint unsigned frame_w, frame_h, box_w, box_h, scale_max, min_win;
    longint unsigned win_w, win_h, at_x, at_y, stride_x, stride_y;
    longint          edge_x, edge_y;
    longint unsigned scales_left, win_count;

    window_t pending_windows[$];
    int      mismatches = 0;
    int      words_checked = 0;
    int      windows_seen = 0;
    int      acks_seen = 0;
    int      grows_seen;
    int      cycles = 0;
    bit      idle_on;

    function automatic longint unsigned rnd_int(longint unsigned v);
        return (v + HALF_FX) >> FRAC;
    endfunction

    function automatic longint unsigned grown(longint unsigned v);
        longint unsigned g;
        g = (v * 6) / 5;
        return (g > WIN_MAX) ? WIN_MAX : g;
    endfunction

    function automatic void place_strides();
        longint unsigned rw, rh, sx, sy;
        rw = rnd_int(win_w);
        rh = rnd_int(win_h);
        sx = (rw << FRAC) / 10;
        sy = (rh << FRAC) / 10;
        stride_x = (sx < sy) ? sx : sy;
        stride_y = sy;
        edge_x = longint'(frame_w << FRAC) - longint'(rw << FRAC) - longint'(ONE_FX);
        edge_y = longint'(frame_h << FRAC) - longint'(rh << FRAC) - longint'(ONE_FX);
    endfunction

    function automatic logic windows_remain();
        return win_w < (frame_w << FRAC) && win_h < (frame_h << FRAC) && scales_left > 0;
    endfunction

    function automatic void reset_shadow();
        frame_w = 320; frame_h = 240; box_w = 32; box_h = 32;
        scale_max = 10; min_win = 24;
        win_w = 0; win_h = 0; at_x = 2 * ONE_FX; at_y = 2 * ONE_FX;
        stride_x = 0; stride_y = 0; edge_x = 0; edge_y = 0;
        scales_left = 0; win_count = 0;
    endfunction

    function automatic window_t next_window(logic restart);
        window_t         w;
        longint unsigned sw, sh, lim6, n, nx, ny;
        w = '0;
        if (restart) begin
            sw = (box_w << FRAC) & WIN_MAX;
            sh = (box_h << FRAC) & WIN_MAX;
            lim6 = 6 * (min_win << FRAC);
            n = 0;
            while (sw * 5 > lim6 && sh * 5 > lim6 && n < scale_max) begin
                sw = (sw * 5) / 6;
                sh = (sh * 5) / 6;
                n++;
            end
            win_w = sw; win_h = sh;
            at_x = 2 * ONE_FX; at_y = 2 * ONE_FX;
            scales_left = scale_max;
            win_count = 0;
            place_strides();
            w.more_windows = windows_remain();
            return w;
        end
        w.box_valid = 1'b1;
        w.box_id    = win_count[23:0];
        w.left_x    = 12'(rnd_int(at_x));
        w.top_y     = 12'(rnd_int(at_y));
        w.right_x   = 13'(rnd_int(at_x + win_w - ONE_FX));
        w.bottom_y  = 13'(rnd_int(at_y + win_h - ONE_FX));
        win_count   = (win_count + 1) & 64'hFF_FFFF;
        nx = at_x + stride_x;
        if (longint'(nx) > edge_x) begin
            ny = at_y + stride_y;
            at_x = 2 * ONE_FX;
            if (longint'(ny) > edge_y) begin
                if (scales_left > 0) scales_left--;
                win_w = grown(win_w);
                win_h = grown(win_h);
                at_y = 2 * ONE_FX;
                place_strides();
                grows_seen++;
            end else begin
                at_y = ny & WIN_MAX;
            end
        end else begin
            at_x = nx & WIN_MAX;
        end
        w.more_windows = windows_remain();
        return w;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_windows.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b1;
        else m_tready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end

    always @(posedge aclk) begin
        window_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.box_valid    = m_tuser;
            got.box_id       = m_tdata[23:0];
            got.left_x       = m_tdata[35:24];
            got.top_y        = m_tdata[47:36];
            got.right_x      = m_tdata[60:48];
            got.bottom_y     = m_tdata[73:61];
            got.more_windows = m_tdata[74];
            words_checked++;
            if (got.box_valid) windows_seen++;
            else acks_seen++;
            if (pending_windows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected word: %p", got);
            end else begin
                want = pending_windows.pop_front();
                if (got !== want || m_tdata[79:75] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch at word %0d\n  exp %p\n  got %p",
                                 words_checked, want, got);
                end
            end
        end
    end

    task automatic send_word(logic restart);
        if (idle_on) begin
            while ($urandom_range(99) < 36) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        pending_windows.push_back(next_window(restart));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge aclk);
        // quiet gap before any register write
        repeat (1000) @(posedge aclk);
    endtask

    task automatic write_regs(input longint unsigned v[6]);
        s_tvalid <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= msw_pkg::CFG_IDX_W'(i);
            cfg_data  <= msw_pkg::CFG_DATA_W'(v[i]);
            do @(posedge aclk); while (!cfg_ready);
            case (msw_pkg::CFG_IDX_W'(i))
                msw_pkg::REG_FRAME_WIDTH:  frame_w   = v[i] & 13'h1FFF;
                msw_pkg::REG_FRAME_HEIGHT: frame_h   = v[i] & 13'h1FFF;
                msw_pkg::REG_BOX_WIDTH:    box_w     = v[i] & 13'h1FFF;
                msw_pkg::REG_BOX_HEIGHT:   box_h     = v[i] & 13'h1FFF;
                msw_pkg::REG_MAX_SCALE:    scale_max = v[i] & 5'h1F;
                msw_pkg::REG_MIN_WINDOW:   min_win   = v[i] & 12'hFFF;
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, int restart_pct);
        for (int i = 0; i < count; i++)
            send_word($urandom_range(99) < restart_pct);
    endtask

    // directed table: typed rows come straight from reset values
    stim_row_t directed[] = '{
        '{1'b0, 1'b1, '{1'b1, 24'd0, 12'd2, 12'd2, 13'd1, 13'd1, 1'b0}},
        '{1'b1, 1'b1, '{1'b0, 24'd0, 12'd0, 12'd0, 13'd0, 13'd0, 1'b1}},
        '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0},
        '{1'b1, 1'b1, '{1'b0, 24'd0, 12'd0, 12'd0, 13'd0, 13'd0, 1'b1}},
        '{1'b0, 1'b0, '0}, '{1'b1, 1'b0, '0}, '{1'b1, 1'b0, '0},
        '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0}, '{1'b0, 1'b0, '0}
    };

    initial begin
        longint unsigned cfg[6];
        window_t         w;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        grows_seen = 0; idle_on = 1'b0;
        reset_shadow();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            w = next_window(directed[i].restart);
            // typed rows expect the value written in the table
            pending_windows.push_back(directed[i].typed ? directed[i].result : w);
            // the shadow already advanced; drive the word without re-predicting
            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, directed[i].restart};
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
        drain();

        // extremes, including a tiny frame that wraps scales often
        cfg = '{4096, 4096, 4096, 4096, 31, 1};    write_regs(cfg);
        send_word(1'b1); run_random(40, 2); drain();
        cfg = '{1, 1, 1, 1, 0, 4095};              write_regs(cfg);
        send_word(1'b1); run_random(30, 5); drain();
        cfg = '{4096, 1, 1, 4096, 31, 4095};       write_regs(cfg);
        send_word(1'b1); run_random(30, 5); drain();

        // quiet stretch with no idling, then idling on both sides
        cfg = '{24, 18, 12, 10, 3, 4};             write_regs(cfg);
        send_word(1'b1); run_random(100, 2); drain();
        idle_on = 1'b1;
        for (int p = 0; p < 6; p++) begin
            cfg[0] = $urandom_range(64, 4);
            cfg[1] = $urandom_range(64, 4);
            cfg[2] = $urandom_range(cfg[0], 1);
            cfg[3] = $urandom_range(cfg[1], 1);
            cfg[4] = $urandom_range(31, 0);
            cfg[5] = $urandom_range(cfg[2] < cfg[3] ? cfg[2] : cfg[3], 1);
            write_regs(cfg);
            send_word(1'b1);
            run_random(80, 3);
            s_tvalid <= 1'b0;
            drain();
        end
        s_tvalid <= 1'b0;
        drain();

        $display("checked %0d words: %0d windows, %0d restart acks, %0d scale grows",
                 words_checked, windows_seen, acks_seen, grows_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> multi_scale_window_scanner.f
+incdir+design
design/msw_pkg.sv
design/msw_cdiv.sv
design/msw_dp.sv
design/msw_ctrl.sv
design/multi_scale_window_scanner.sv
tb/sv/multi_scale_window_scanner_tb.sv
